// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared shorthand for clocked concurrent assertions
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while reset is active
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds across reset
`define ASSERT_CLK_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/upsc_pkg.sv
// ----------------------------------------------------------------------------
// upsc_pkg
// types and constants shared by the heat-map upscaler modules
// ----------------------------------------------------------------------------
package upsc_pkg;

    // item kinds carried in s_tuser
    typedef enum logic [1:0] {
        KIND_SAMPLE  = 2'd0,
        KIND_PALETTE = 2'd1,
        KIND_PIXEL   = 2'd2
    } kind_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_BILINEAR_MODE     = 3'd0,
        CFG_MIRROR_HORIZONTAL = 3'd1,
        CFG_MIRROR_VERTICAL   = 3'd2,
        CFG_COLUMN_STEP       = 3'd3,
        CFG_ROW_STEP          = 3'd4
    } cfg_index_t;

    // field widths
    localparam int KIND_W  = 2;
    localparam int INDEX_W = 10;
    localparam int WDATA_W = 16;
    localparam int COORD_W = 7;
    localparam int HEAT_W  = 8;
    localparam int COLOR_W = 16;
    localparam int STEP_W  = 7;

    // fixed point position format
    localparam int FRAC_BITS = 7;
    localparam int POS_W     = 2 * COORD_W;

    // reciprocal scaling for the nearest-neighbour block divide
    localparam int NEAR_SHIFT = 16;
    localparam int NEAR_W     = 24;

    // reset values of the configuration registers
    localparam logic              RST_BILINEAR_MODE     = 1'b1;
    localparam logic              RST_MIRROR_HORIZONTAL = 1'b1;
    localparam logic              RST_MIRROR_VERTICAL   = 1'b0;
    localparam logic [STEP_W-1:0] RST_COLUMN_STEP       = 7'd31;
    localparam logic [STEP_W-1:0] RST_ROW_STEP          = 7'd30;

    // result buffer sized to cover every request in the pipeline
    localparam int OUT_FIFO_DEPTH = 8;
    localparam int OUT_PTR_W      = $clog2(OUT_FIFO_DEPTH);

    // one result item
    typedef struct packed {
        logic [COLOR_W-1:0] pixel_color;
        logic [COORD_W-1:0] display_column;
        logic [COORD_W-1:0] display_row;
    } out_item_t;

endpackage

// File: hdl/upsc_sample_mem.sv
// ----------------------------------------------------------------------------
// upsc_sample_mem
// heat sample store, two replicas with two registered read ports each
// ----------------------------------------------------------------------------
module upsc_sample_mem
    import upsc_pkg::*;
#(
    parameter int DEPTH = 768
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [HEAT_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_top_lo,
    input  logic [$clog2(DEPTH)-1:0] raddr_top_hi,
    input  logic [$clog2(DEPTH)-1:0] raddr_bot_lo,
    input  logic [$clog2(DEPTH)-1:0] raddr_bot_hi,
    output logic [HEAT_W-1:0]        rdata_top_lo,
    output logic [HEAT_W-1:0]        rdata_top_hi,
    output logic [HEAT_W-1:0]        rdata_bot_lo,
    output logic [HEAT_W-1:0]        rdata_bot_hi
);

    logic [HEAT_W-1:0] top_mem [DEPTH];
    logic [HEAT_W-1:0] bot_mem [DEPTH];

    // both replicas take every write
    always_ff @(posedge aclk) begin
        if (we) begin
            top_mem[waddr] <= wdata;
            bot_mem[waddr] <= wdata;
        end
    end

    // top row neighbours from one replica, bottom row from the other
    always_ff @(posedge aclk) begin
        rdata_top_lo <= top_mem[raddr_top_lo];
        rdata_top_hi <= top_mem[raddr_top_hi];
        rdata_bot_lo <= bot_mem[raddr_bot_lo];
        rdata_bot_hi <= bot_mem[raddr_bot_hi];
    end

endmodule

// File: hdl/upsc_palette_mem.sv
// ----------------------------------------------------------------------------
// upsc_palette_mem
// rgb565 palette store with one write port and one registered read port
// ----------------------------------------------------------------------------
module upsc_palette_mem
    import upsc_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [COLOR_W-1:0]       wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [COLOR_W-1:0]       rdata
);

    logic [COLOR_W-1:0] pal_mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            pal_mem[waddr] <= wdata;
        end
    end

    // registered read
    always_ff @(posedge aclk) begin
        rdata <= pal_mem[raddr];
    end

endmodule

// File: hdl/upsc_out_fifo.sv
// ----------------------------------------------------------------------------
// upsc_out_fifo
// result buffer between the pipeline and the master side
// ----------------------------------------------------------------------------
module upsc_out_fifo
    import upsc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  out_item_t push_item,
    input  logic      pop_ready,
    output logic      head_valid,
    output out_item_t head_item
);

    out_item_t              buf_reg [OUT_FIFO_DEPTH];
    logic [OUT_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [OUT_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [OUT_PTR_W:0]     count_reg, count_next;
    logic                   pop;

    assign head_valid = (count_reg != '0);
    assign head_item  = buf_reg[rd_ptr_reg];
    assign pop        = head_valid && pop_ready;

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = push ? OUT_PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? OUT_PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = (OUT_PTR_W + 1)'(count_reg + 1'b1);
        end else if (pop && !push) begin
            count_next = (OUT_PTR_W + 1)'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset needed
    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: hdl/bilinear_heatmap_upscaler_top.sv
// ----------------------------------------------------------------------------
// bilinear_heatmap_upscaler_top
// heat-map upscaler: sample frame and palette stores, bilinear pipeline
// ----------------------------------------------------------------------------
// The slave stream carries three kinds of item, chosen by s_tuser: a sample
// write, a palette write and a pixel request. Writes give no result; each
// pixel request gives one master item with the palette colour and the
// mirrored display coordinates. The cfg channel writes the mode, mirror and
// step registers and is always ready; it must be written only while idle,
// which the block does not enforce. Throughput is one item per clock while
// s_tready is high. A request goes through four stages: position multiply,
// sample read (four neighbours from two dual-read replicas), horizontal
// blend, vertical blend with palette read. Stores are read and written in
// one stage each and items stay in order, so writes and reads of the same
// entry never overlap. Up to eight requests may be outstanding; a result
// buffer of that depth sits before the master side, so the slave side keeps
// accepting while results wait, and s_tready drops only once eight requests
// are outstanding behind a stalled receiver. Reset clears the registers,
// the pipeline and the buffer; the stores hold no reset value and must be
// read only after being written (not enforced); no clearing pass runs.
// ----------------------------------------------------------------------------
module bilinear_heatmap_upscaler_top
    import upsc_pkg::*;
#(
    parameter int SENSOR_COLUMNS = 32,
    parameter int SENSOR_ROWS    = 24,
    parameter int OUTPUT_WIDTH   = 128,
    parameter int OUTPUT_HEIGHT  = 96,
    parameter int BLOCK_SIZE     = 4,
    parameter int PALETTE_DEPTH  = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    // slave side
    input  logic        s_tvalid,
    output logic        s_tready,
    // entry_index[9:0], write_data[25:10], pixel_column[32:26], pixel_row[39:33]
    input  logic [39:0] s_tdata,
    // kind[1:0]
    input  logic [1:0]  s_tuser,
    // master side
    output logic        m_tvalid,
    input  logic        m_tready,
    // pixel_color[15:0], display_column[22:16], display_row[29:23], zero[31:30]
    output logic [31:0] m_tdata,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [6:0]  cfg_data
);

    localparam int SAMPLE_COUNT = SENSOR_COLUMNS * SENSOR_ROWS;
    localparam int SAMPLE_AW    = $clog2(SAMPLE_COUNT);
    localparam int PAL_AW       = $clog2(PALETTE_DEPTH);
    localparam int COL_W        = $clog2(SENSOR_COLUMNS);
    localparam int ROW_W        = $clog2(SENSOR_ROWS);
    localparam int X_LAST       = OUTPUT_WIDTH - 1;
    localparam int Y_LAST       = OUTPUT_HEIGHT - 1;
    localparam int NEAR_RECIP   = ((1 << NEAR_SHIFT) + BLOCK_SIZE - 1) / BLOCK_SIZE;
    localparam logic signed [10:0] HEAT_MAX = 11'(PALETTE_DEPTH - 1);

    // configuration registers
    logic              bilinear_mode_reg;
    logic              mirror_h_reg;
    logic              mirror_v_reg;
    logic [STEP_W-1:0] column_step_reg;
    logic [STEP_W-1:0] row_step_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bilinear_mode_reg <= RST_BILINEAR_MODE;
            mirror_h_reg      <= RST_MIRROR_HORIZONTAL;
            mirror_v_reg      <= RST_MIRROR_VERTICAL;
            column_step_reg   <= RST_COLUMN_STEP;
            row_step_reg      <= RST_ROW_STEP;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_BILINEAR_MODE:     bilinear_mode_reg <= cfg_data[0];
                CFG_MIRROR_HORIZONTAL: mirror_h_reg      <= cfg_data[0];
                CFG_MIRROR_VERTICAL:   mirror_v_reg      <= cfg_data[0];
                CFG_COLUMN_STEP:       column_step_reg   <= cfg_data;
                CFG_ROW_STEP:          row_step_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    // slave side fields
    logic [KIND_W-1:0]  in_kind;
    logic [INDEX_W-1:0] in_index;
    logic [WDATA_W-1:0] in_wdata;
    logic [COORD_W-1:0] in_col;
    logic [COORD_W-1:0] in_row;

    assign in_kind  = s_tuser[1:0];
    assign in_index = s_tdata[9:0];
    assign in_wdata = s_tdata[25:10];
    assign in_col   = s_tdata[32:26];
    assign in_row   = s_tdata[39:33];

    // credit count of requests not yet delivered
    logic                 in_accept;
    logic                 req_accept;
    logic                 out_pop;
    logic [OUT_PTR_W:0]   occ_reg, occ_next;

    assign s_tready   = (occ_reg < (OUT_PTR_W + 1)'(OUT_FIFO_DEPTH));
    assign in_accept  = s_tvalid && s_tready;
    assign req_accept = in_accept && (in_kind == KIND_PIXEL);
    assign out_pop    = m_tvalid && m_tready;

    always_comb begin
        occ_next = occ_reg;
        if (req_accept && !out_pop) begin
            occ_next = (OUT_PTR_W + 1)'(occ_reg + 1'b1);
        end else if (out_pop && !req_accept) begin
            occ_next = (OUT_PTR_W + 1)'(occ_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    // ---------------- entry stage: saturate, mirror, position multiply
    logic [COORD_W-1:0] x_sat, y_sat;
    logic [POS_W-1:0]   col_pos, row_pos;
    logic [NEAR_W-1:0]  col_near_prod, row_near_prod;
    logic [COORD_W-1:0] col_int_next, row_int_next;
    logic [FRAC_BITS-1:0] tx_next, ty_next;
    logic [COORD_W-1:0] dcol_next, drow_next;
    logic               sample_we_next, pal_we_next, pixel_next;

    always_comb begin
        x_sat = (32'(in_col) > X_LAST) ? COORD_W'(X_LAST) : in_col;
        y_sat = (32'(in_row) > Y_LAST) ? COORD_W'(Y_LAST) : in_row;

        col_pos       = POS_W'(x_sat) * POS_W'(column_step_reg);
        row_pos       = POS_W'(y_sat) * POS_W'(row_step_reg);
        col_near_prod = NEAR_W'(x_sat) * NEAR_W'(NEAR_RECIP);
        row_near_prod = NEAR_W'(y_sat) * NEAR_W'(NEAR_RECIP);

        // nearest mode is the blend with a zero fraction
        if (bilinear_mode_reg) begin
            col_int_next = col_pos[POS_W-1:FRAC_BITS];
            row_int_next = row_pos[POS_W-1:FRAC_BITS];
            tx_next      = col_pos[FRAC_BITS-1:0];
            ty_next      = row_pos[FRAC_BITS-1:0];
        end else begin
            col_int_next = COORD_W'(col_near_prod >> NEAR_SHIFT);
            row_int_next = COORD_W'(row_near_prod >> NEAR_SHIFT);
            tx_next      = '0;
            ty_next      = '0;
        end

        dcol_next = mirror_h_reg ? COORD_W'(X_LAST - int'(x_sat)) : x_sat;
        drow_next = mirror_v_reg ? COORD_W'(Y_LAST - int'(y_sat)) : y_sat;

        // out of range writes are dropped here
        sample_we_next = in_accept && (in_kind == KIND_SAMPLE)
                         && (32'(in_index) < SAMPLE_COUNT);
        pal_we_next    = in_accept && (in_kind == KIND_PALETTE)
                         && (32'(in_index) < PALETTE_DEPTH);
        pixel_next     = req_accept;
    end

    logic                 a_sample_we_reg, a_pal_we_reg, a_pixel_reg;
    logic [INDEX_W-1:0]   a_index_reg;
    logic [WDATA_W-1:0]   a_wdata_reg;
    logic [COORD_W-1:0]   a_col_reg, a_row_reg;
    logic [FRAC_BITS-1:0] a_tx_reg, a_ty_reg;
    logic [COORD_W-1:0]   a_dcol_reg, a_drow_reg;

    // ---------------- read stage: clamp neighbours, sample access
    logic [COL_W-1:0]     col_lo, col_hi;
    logic [ROW_W-1:0]     row_lo, row_hi;
    logic [SAMPLE_AW-1:0] addr_top_lo, addr_top_hi, addr_bot_lo, addr_bot_hi;

    always_comb begin
        col_lo = (32'(a_col_reg) > SENSOR_COLUMNS - 1) ?
                 COL_W'(SENSOR_COLUMNS - 1) : COL_W'(a_col_reg);
        col_hi = (32'(a_col_reg) + 1 > SENSOR_COLUMNS - 1) ?
                 COL_W'(SENSOR_COLUMNS - 1) : COL_W'(a_col_reg + 1'b1);
        row_lo = (32'(a_row_reg) > SENSOR_ROWS - 1) ?
                 ROW_W'(SENSOR_ROWS - 1) : ROW_W'(a_row_reg);
        row_hi = (32'(a_row_reg) + 1 > SENSOR_ROWS - 1) ?
                 ROW_W'(SENSOR_ROWS - 1) : ROW_W'(a_row_reg + 1'b1);

        addr_top_lo = SAMPLE_AW'(int'(row_lo) * SENSOR_COLUMNS + int'(col_lo));
        addr_top_hi = SAMPLE_AW'(int'(row_lo) * SENSOR_COLUMNS + int'(col_hi));
        addr_bot_lo = SAMPLE_AW'(int'(row_hi) * SENSOR_COLUMNS + int'(col_lo));
        addr_bot_hi = SAMPLE_AW'(int'(row_hi) * SENSOR_COLUMNS + int'(col_hi));
    end

    logic [HEAT_W-1:0] v00, v10, v01, v11;

    upsc_sample_mem #(
        .DEPTH (SAMPLE_COUNT)
    ) u_sample_mem (
        .aclk         (aclk),
        .we           (a_sample_we_reg),
        .waddr        (SAMPLE_AW'(a_index_reg)),
        .wdata        (a_wdata_reg[HEAT_W-1:0]),
        .raddr_top_lo (addr_top_lo),
        .raddr_top_hi (addr_top_hi),
        .raddr_bot_lo (addr_bot_lo),
        .raddr_bot_hi (addr_bot_hi),
        .rdata_top_lo (v00),
        .rdata_top_hi (v10),
        .rdata_bot_lo (v01),
        .rdata_bot_hi (v11)
    );

    logic                 b_pal_we_reg, b_pixel_reg;
    logic [INDEX_W-1:0]   b_index_reg;
    logic [WDATA_W-1:0]   b_wdata_reg;
    logic [FRAC_BITS-1:0] b_tx_reg, b_ty_reg;
    logic [COORD_W-1:0]   b_dcol_reg, b_drow_reg;

    // ---------------- horizontal blend
    logic signed [9:0]  top_diff, bot_diff;
    logic signed [17:0] top_prod, bot_prod;
    logic signed [9:0]  top_next, bot_next;

    always_comb begin
        top_diff = $signed({2'b00, v10}) - $signed({2'b00, v00});
        bot_diff = $signed({2'b00, v11}) - $signed({2'b00, v01});
        top_prod = $signed({1'b0, b_tx_reg}) * top_diff;
        bot_prod = $signed({1'b0, b_tx_reg}) * bot_diff;
        // arithmetic shift gives the floor
        top_next = 10'($signed({2'b00, v00}) + (top_prod >>> FRAC_BITS));
        bot_next = 10'($signed({2'b00, v01}) + (bot_prod >>> FRAC_BITS));
    end

    logic                 c_pal_we_reg, c_pixel_reg;
    logic [INDEX_W-1:0]   c_index_reg;
    logic [WDATA_W-1:0]   c_wdata_reg;
    logic [FRAC_BITS-1:0] c_ty_reg;
    logic [COORD_W-1:0]   c_dcol_reg, c_drow_reg;
    logic signed [9:0]    c_top_reg, c_bot_reg;

    // ---------------- vertical blend, heat clamp, palette access
    logic signed [10:0] vert_diff;
    logic signed [18:0] vert_prod;
    logic signed [10:0] heat_s;
    logic [PAL_AW-1:0]  pal_raddr;

    always_comb begin
        vert_diff = c_bot_reg - c_top_reg;
        vert_prod = $signed({1'b0, c_ty_reg}) * vert_diff;
        heat_s    = 11'(c_top_reg + (vert_prod >>> FRAC_BITS));
        if (heat_s < 0) begin
            pal_raddr = '0;
        end else if (heat_s > HEAT_MAX) begin
            pal_raddr = PAL_AW'(HEAT_MAX);
        end else begin
            pal_raddr = PAL_AW'(heat_s);
        end
    end

    logic [COLOR_W-1:0] pal_rdata;

    upsc_palette_mem #(
        .DEPTH (PALETTE_DEPTH)
    ) u_palette_mem (
        .aclk  (aclk),
        .we    (c_pal_we_reg),
        .waddr (PAL_AW'(c_index_reg)),
        .wdata (c_wdata_reg),
        .raddr (pal_raddr),
        .rdata (pal_rdata)
    );

    logic               d_pixel_reg;
    logic [COORD_W-1:0] d_dcol_reg, d_drow_reg;

    // pipeline control bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_sample_we_reg <= 1'b0;
            a_pal_we_reg    <= 1'b0;
            a_pixel_reg     <= 1'b0;
            b_pal_we_reg    <= 1'b0;
            b_pixel_reg     <= 1'b0;
            c_pal_we_reg    <= 1'b0;
            c_pixel_reg     <= 1'b0;
            d_pixel_reg     <= 1'b0;
        end else begin
            a_sample_we_reg <= sample_we_next;
            a_pal_we_reg    <= pal_we_next;
            a_pixel_reg     <= pixel_next;
            b_pal_we_reg    <= a_pal_we_reg;
            b_pixel_reg     <= a_pixel_reg;
            c_pal_we_reg    <= b_pal_we_reg;
            c_pixel_reg     <= b_pixel_reg;
            d_pixel_reg     <= c_pixel_reg;
        end
    end

    // pipeline payload
    always_ff @(posedge aclk) begin
        a_index_reg <= in_index;
        a_wdata_reg <= in_wdata;
        a_col_reg   <= col_int_next;
        a_row_reg   <= row_int_next;
        a_tx_reg    <= tx_next;
        a_ty_reg    <= ty_next;
        a_dcol_reg  <= dcol_next;
        a_drow_reg  <= drow_next;

        b_index_reg <= a_index_reg;
        b_wdata_reg <= a_wdata_reg;
        b_tx_reg    <= a_tx_reg;
        b_ty_reg    <= a_ty_reg;
        b_dcol_reg  <= a_dcol_reg;
        b_drow_reg  <= a_drow_reg;

        c_index_reg <= b_index_reg;
        c_wdata_reg <= b_wdata_reg;
        c_ty_reg    <= b_ty_reg;
        c_top_reg   <= top_next;
        c_bot_reg   <= bot_next;
        c_dcol_reg  <= b_dcol_reg;
        c_drow_reg  <= b_drow_reg;

        d_dcol_reg  <= c_dcol_reg;
        d_drow_reg  <= c_drow_reg;
    end

    // ---------------- result buffer and master side
    out_item_t push_item;
    out_item_t head_item;

    always_comb begin
        push_item.pixel_color    = pal_rdata;
        push_item.display_column = d_dcol_reg;
        push_item.display_row    = d_drow_reg;
    end

    upsc_out_fifo u_out_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (d_pixel_reg),
        .push_item  (push_item),
        .pop_ready  (m_tready),
        .head_valid (m_tvalid),
        .head_item  (head_item)
    );

    assign m_tdata = {2'b00, head_item.display_row, head_item.display_column,
                      head_item.pixel_color};

endmodule

// File: hdl/upsc_checker.sv
// ----------------------------------------------------------------------------
// upsc_checker
// port-level checks of the heat-map upscaler, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module upsc_checker
    import upsc_pkg::*;
#(
    parameter int OUTPUT_WIDTH  = 128,
    parameter int OUTPUT_HEIGHT = 96
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // requests accepted and not yet delivered
    logic [4:0] pending_reg, pending_next;
    logic       req_seen, res_seen;

    assign req_seen = s_tvalid && s_tready && (s_tuser == KIND_PIXEL);
    assign res_seen = m_tvalid && m_tready;

    always_comb begin
        pending_next = pending_reg;
        if (req_seen && !res_seen) begin
            pending_next = 5'(pending_reg + 1'b1);
        end else if (res_seen && !req_seen) begin
            pending_next = 5'(pending_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    // a stalled result stays offered and unchanged
    `ASSERT_CLK(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
    `ASSERT_CLK(a_hold_data, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata), "result changed while stalled")

    // every result answers an earlier request
    `ASSERT_CLK(a_no_extra, aclk, aresetn, m_tvalid |-> pending_reg != 5'd0, "result without a pending request")

    // display coordinates stay on the grid
    `ASSERT_CLK(a_coord_range, aclk, aresetn, m_tvalid |-> (32'(m_tdata[22:16]) < OUTPUT_WIDTH) && (32'(m_tdata[29:23]) < OUTPUT_HEIGHT), "display coordinate off the grid")

    // reset empties the result path
    `ASSERT_CLK_NORST(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result offered after reset")

endmodule

bind bilinear_heatmap_upscaler_top upsc_checker #(
    .OUTPUT_WIDTH  (OUTPUT_WIDTH),
    .OUTPUT_HEIGHT (OUTPUT_HEIGHT)
) u_upsc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
